>>> rtl/core/rdde_pkg.sv
// Package for the reversible deque drop engine.
// Holds operation and status codes and default sizes; no dependencies.
package rdde_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int VALUE_WIDTH_DEF = 16;

  // Operation selector on the request port
  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PUSH    = 3'd1,
    OP_REVERSE = 3'd2,
    OP_DROP    = 3'd3,
    OP_READ    = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

>>> rtl/core/rdde_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module rdde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/reversible_deque_drop_engine.sv
// Top level of the reversible deque drop engine: ring store with lazy reverse.
// Depends on rdde_pkg and rdde_ram.
//
//  Channel   Ports                                              Handshake
//  request   in_func, in_value                                  start & !busy
//  result    out_status, out_data_out, out_remaining, out_last  out_valid strobe
//
//  Each request gives one result in the cycle after it is taken; busy stays low,
//  so a request can be taken every cycle (one request per cycle).
//  A read goes through the single store port: the entry is addressed
//  at the accept edge and its registered data drives out_data_out in the result cycle.
//  Reset (rst_n low, synchronous) empties the list and clears both flags; the
//  store itself is not cleared, since only held entries are ever read.
//  The receiver cannot stall: each result is shown for exactly one cycle.
module reversible_deque_drop_engine
  import rdde_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_func,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [VALUE_WIDTH-1:0] out_data_out,
  output logic [CW-1:0]          out_remaining,
  output logic                   out_last
);

  localparam int SW = CW + 1;

  logic             accept;
  func_t            func;

  logic [AW-1:0]    front_r, front_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             rev_r, rev_nxt;
  logic             err_r, err_nxt;

  logic             valid_r;
  status_t          status_r, status_nxt;
  logic [CW-1:0]    remain_r;
  logic             last_r, last_nxt;
  logic             rd_pend_r, rd_pend_nxt;

  logic [AW-1:0]    front_inc, front_dec, tail_inc, tail_dec;
  logic             empty, full;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign func   = func_t'(in_func);

  // Ring pointer steps with wrap at DEPTH
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign tail_inc  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec  = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - 1'b1;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));

  // Decode the request: pointer updates, store access and result fields
  always_comb begin
    front_nxt   = front_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    err_nxt     = err_r;
    status_nxt  = ST_OK;
    last_nxt    = 1'b0;
    rd_pend_nxt = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = tail_r;
    if (accept) begin
      case (func)
        OP_CLEAR: begin
          front_nxt = '0;
          tail_nxt  = '0;
          count_nxt = '0;
          rev_nxt   = 1'b0;
          err_nxt   = 1'b0;
        end
        OP_PUSH: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else if (rev_r) begin
            // append at the logical back, which is the physical front
            front_nxt = front_dec;
            ram_addr  = front_dec;
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ram_addr  = tail_r;
            ram_we    = 1'b1;
            tail_nxt  = tail_inc;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REVERSE: begin
          if (err_r) begin
            status_nxt = ST_ERROR;
          end else begin
            rev_nxt = !rev_r;
          end
        end
        OP_DROP, OP_READ: begin
          if (err_r) begin
            status_nxt = ST_ERROR;
          end else if (empty) begin
            if (func == OP_DROP) begin
              err_nxt    = 1'b1;
              status_nxt = ST_ERROR;
            end else begin
              status_nxt = ST_EMPTY;
            end
          end else begin
            // pop the logical first element
            if (rev_r) begin
              tail_nxt = tail_dec;
              ram_addr = tail_dec;
            end else begin
              front_nxt = front_inc;
              ram_addr  = front_r;
            end
            count_nxt = count_r - 1'b1;
            if (func == OP_READ) begin
              ram_re      = 1'b1;
              rd_pend_nxt = 1'b1;
              last_nxt    = (count_r == CW'(1));
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold list state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      rev_r     <= 1'b0;
      err_r     <= 1'b0;
      valid_r   <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      front_r   <= front_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      rev_r     <= rev_nxt;
      err_r     <= err_nxt;
      valid_r   <= accept;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    remain_r <= count_nxt;
    last_r   <= last_nxt;
  end

  rdde_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  // Drive the result ports
  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_data_out  = rd_pend_r ? ram_rdata : '0;
  assign out_remaining = remain_r;
  assign out_last      = last_r;

  // Tail must always sit count entries past front on the ring
  logic [SW-1:0] ring_sum;
  logic [SW-1:0] ring_pos;
  assign ring_sum = SW'(front_r) + SW'(count_r);
  assign ring_pos = (ring_sum >= SW'(DEPTH)) ? ring_sum - SW'(DEPTH) : ring_sum;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above store depth");

  a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(ring_pos) == tail_r)
    else $error("tail pointer out of step with front and count");

  a_err_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func == OP_READ && err_r |=> out_status == ST_ERROR && out_data_out == '0)
    else $error("read under sticky error not reported");

  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_remaining == '0 && out_status == ST_OK)
    else $error("last flag with elements still held");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(accept && func == OP_CLEAR) |=> err_r)
    else $error("sticky error dropped without clear");

endmodule
